@@ design/tnet_pkg.sv @@
// Shared types and constants for the top-N error tracker.
// Used by every module of the block; no dependencies.
`default_nettype none

package tnet_pkg;

    localparam int CMD_W      = 3;
    localparam int ERR_W      = 32;
    localparam int IDX_W      = 24;
    localparam int RANK_W     = 4;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 144;
    localparam int M_PAD_W    = M_TDATA_W - (RANK_W + ERR_W + IDX_W + SUM_W + CNT_W);
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_DOWN_EN = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 3'd0,
        CMD_ADD_SAME  = 3'd1,
        CMD_ADD_DOWN  = 3'd2,
        CMD_RD_SAME   = 3'd3,
        CMD_RD_DOWN   = 3'd4,
        CMD_RD_MERGED = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        RD_SAME,
        RD_DOWN,
        RD_MERGED
    } t_rd_kind;

    typedef struct packed {
        logic clr;
        logic add;
        logic rot;
    } t_cls_cmd;

    typedef struct packed {
        t_cls_cmd           same;
        t_cls_cmd           down;
        logic               load;
        logic               pick_a;
        logic               pick_b;
        logic               last;
        logic [RANK_W-1:0]  rank;
        t_rd_kind           kind;
    } t_dp_cmd;

    typedef struct packed {
        logic a_head_vld;
        logic a_next_vld;
        logic b_head_vld;
        logic b_next_vld;
        logic a_ge_b;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/tnet_class.sv @@
// One error class: ranked list with parallel compare-and-shift insert,
// rotate for readout, saturating sum and count. Depends on tnet_pkg.
`default_nettype none

module tnet_class #(
    parameter int TOP_COUNT = 10,
    parameter int KEEP_W    = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tnet_pkg::t_cls_cmd            i_cmd,
    input  wire logic [tnet_pkg::ERR_W-1:0]    i_err,
    input  wire logic [KEEP_W-1:0]             i_idx,
    output logic                               o_head_vld,
    output logic                               o_next_vld,
    output logic [tnet_pkg::ERR_W-1:0]         o_head_err,
    output logic [KEEP_W-1:0]                  o_head_idx,
    output logic [tnet_pkg::SUM_W-1:0]         o_sum,
    output logic [tnet_pkg::CNT_W-1:0]         o_count
);

    localparam int ErrW    = tnet_pkg::ERR_W;
    localparam int SumW    = tnet_pkg::SUM_W;
    localparam int CntW    = tnet_pkg::CNT_W;
    localparam int NextIdx = (TOP_COUNT > 1) ? 1 : 0;

    logic [TOP_COUNT-1:0] r_vld;
    logic [TOP_COUNT-1:0] n_vld;
    logic [ErrW-1:0]      r_err [TOP_COUNT];
    logic [ErrW-1:0]      n_err [TOP_COUNT];
    logic [KEEP_W-1:0]    r_idx [TOP_COUNT];
    logic [KEEP_W-1:0]    n_idx [TOP_COUNT];
    logic [TOP_COUNT-1:0] w_ins;
    logic [TOP_COUNT-1:0] w_first;
    logic [SumW-1:0]      r_sum;
    logic [SumW-1:0]      n_sum;
    logic [CntW-1:0]      r_count;
    logic [CntW-1:0]      n_count;
    logic [SumW:0]        w_sum_ext;

    // an entry is displaced when it is empty or strictly smaller
    always_comb begin
        int prv;
        for (int i = 0; i < TOP_COUNT; i++) begin
            prv        = (i == 0) ? 0 : i - 1;
            w_ins[i]   = !r_vld[i] || (i_err > r_err[i]);
            w_first[i] = w_ins[i] && ((i == 0) || !(!r_vld[prv] || (i_err > r_err[prv])));
        end
    end

    always_comb begin
        int prv;
        int nxt;
        for (int i = 0; i < TOP_COUNT; i++) begin
            prv      = (i == 0) ? 0 : i - 1;
            nxt      = (i + 1) % TOP_COUNT;
            n_vld[i] = r_vld[i];
            n_err[i] = r_err[i];
            n_idx[i] = r_idx[i];
            if (i_cmd.clr) begin
                n_vld[i] = 1'b0;
            end else if (i_cmd.add && w_ins[i]) begin
                if (w_first[i]) begin
                    n_vld[i] = 1'b1;
                    n_err[i] = i_err;
                    n_idx[i] = i_idx;
                end else begin
                    n_vld[i] = r_vld[prv];
                    n_err[i] = r_err[prv];
                    n_idx[i] = r_idx[prv];
                end
            end else if (i_cmd.rot) begin
                n_vld[i] = r_vld[nxt];
                n_err[i] = r_err[nxt];
                n_idx[i] = r_idx[nxt];
            end
        end
    end

    assign w_sum_ext = {1'b0, r_sum} + {{(SumW + 1 - ErrW){1'b0}}, i_err};

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        if (i_cmd.clr) begin
            n_sum   = '0;
            n_count = '0;
        end else if (i_cmd.add) begin
            n_sum = w_sum_ext[SumW] ? {SumW{1'b1}} : w_sum_ext[SumW-1:0];
            if (r_count != {CntW{1'b1}}) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_vld   <= n_vld;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= n_err;
        r_idx <= n_idx;
    end

    assign o_head_vld = r_vld[0];
    assign o_next_vld = (TOP_COUNT > 1) && r_vld[NextIdx];
    assign o_head_err = r_err[0];
    assign o_head_idx = r_idx[0];
    assign o_sum      = r_sum;
    assign o_count    = r_count;

endmodule

`default_nettype wire

@@ design/tnet_dp.sv @@
// Datapath: both class lists, merged sum/count and the result register.
// Depends on tnet_pkg and tnet_class.
`default_nettype none

module tnet_dp #(
    parameter int TOP_COUNT = 10,
    parameter int KEEP_W    = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tnet_pkg::t_dp_cmd                 i_cmd,
    output tnet_pkg::t_dp_stat                     o_stat,
    input  wire logic [tnet_pkg::ERR_W-1:0]        i_err,
    input  wire logic [KEEP_W-1:0]                 i_idx,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic [tnet_pkg::M_TDATA_W-1:0]         o_tdata,
    output logic                                   o_tuser,
    output logic                                   o_tlast
);

    localparam int ErrW  = tnet_pkg::ERR_W;
    localparam int IdxW  = tnet_pkg::IDX_W;
    localparam int SumW  = tnet_pkg::SUM_W;
    localparam int CntW  = tnet_pkg::CNT_W;
    localparam int RankW = tnet_pkg::RANK_W;
    localparam int PadW  = tnet_pkg::M_PAD_W;

    logic              a_vld, a_nvld, b_vld, b_nvld;
    logic [ErrW-1:0]   a_err, b_err;
    logic [KEEP_W-1:0] a_idx, b_idx;
    logic [SumW-1:0]   a_sum, b_sum, w_sum;
    logic [CntW-1:0]   a_cnt, b_cnt, w_cnt;
    logic [SumW:0]     w_msum;
    logic [CntW:0]     w_mcnt;

    logic              r_tvalid;
    logic [RankW-1:0]  r_rank;
    logic              r_evld;
    logic [ErrW-1:0]   r_err;
    logic [IdxW-1:0]   r_idx;
    logic [SumW-1:0]   r_sum;
    logic [CntW-1:0]   r_cnt;
    logic              r_last;

    tnet_class #(.TOP_COUNT(TOP_COUNT), .KEEP_W(KEEP_W)) u_same (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd.same),
        .i_err      (i_err),
        .i_idx      (i_idx),
        .o_head_vld (a_vld),
        .o_next_vld (a_nvld),
        .o_head_err (a_err),
        .o_head_idx (a_idx),
        .o_sum      (a_sum),
        .o_count    (a_cnt)
    );

    tnet_class #(.TOP_COUNT(TOP_COUNT), .KEEP_W(KEEP_W)) u_down (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd.down),
        .i_err      (i_err),
        .i_idx      (i_idx),
        .o_head_vld (b_vld),
        .o_next_vld (b_nvld),
        .o_head_err (b_err),
        .o_head_idx (b_idx),
        .o_sum      (b_sum),
        .o_count    (b_cnt)
    );

    assign w_msum = {1'b0, a_sum} + {1'b0, b_sum};
    assign w_mcnt = {1'b0, a_cnt} + {1'b0, b_cnt};

    always_comb begin
        case (i_cmd.kind)
            tnet_pkg::RD_SAME: begin
                w_sum = a_sum;
                w_cnt = a_cnt;
            end
            tnet_pkg::RD_DOWN: begin
                w_sum = b_sum;
                w_cnt = b_cnt;
            end
            tnet_pkg::RD_MERGED: begin
                w_sum = w_msum[SumW] ? {SumW{1'b1}} : w_msum[SumW-1:0];
                w_cnt = w_mcnt[CntW] ? {CntW{1'b1}} : w_mcnt[CntW-1:0];
            end
            default: begin
                w_sum = '0;
                w_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_tvalid <= 1'b1;
        end else if (i_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rank <= i_cmd.rank;
            r_last <= i_cmd.last;
            r_sum  <= w_sum;
            r_cnt  <= w_cnt;
            if (i_cmd.pick_a) begin
                r_evld <= 1'b1;
                r_err  <= a_err;
                r_idx  <= IdxW'(a_idx);
            end else if (i_cmd.pick_b) begin
                r_evld <= 1'b1;
                r_err  <= b_err;
                r_idx  <= IdxW'(b_idx);
            end else begin
                r_evld <= 1'b0;
                r_err  <= '0;
                r_idx  <= '0;
            end
        end
    end

    assign o_stat.a_head_vld = a_vld;
    assign o_stat.a_next_vld = a_nvld;
    assign o_stat.b_head_vld = b_vld;
    assign o_stat.b_next_vld = b_nvld;
    assign o_stat.a_ge_b     = (a_err >= b_err);
    assign o_stat.out_free   = !r_tvalid || i_tready;

    assign o_tvalid = r_tvalid;
    assign o_tdata  = {{PadW{1'b0}}, r_cnt, r_sum, r_idx, r_err, r_rank};
    assign o_tuser  = r_evld;
    assign o_tlast  = r_last;

endmodule

`default_nettype wire

@@ design/tnet_ctrl.sv @@
// Controller: command decode, read sequencer (emit then restore rotation)
// and the configuration register. Depends on tnet_pkg.
`default_nettype none

module tnet_ctrl #(
    parameter int TOP_COUNT = 10
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_tvalid,
    output logic                                      o_tready,
    input  wire logic [tnet_pkg::CMD_W-1:0]           i_cmd,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tnet_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [tnet_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tnet_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready,
    output tnet_pkg::t_dp_cmd                         o_dp_cmd,
    input  wire tnet_pkg::t_dp_stat                   i_dp_stat
);

    localparam int AddrW = tnet_pkg::APB_ADDR_W;
    localparam int DataW = tnet_pkg::APB_DATA_W;
    localparam int RankW = tnet_pkg::RANK_W;
    localparam int CntW  = $clog2(TOP_COUNT + 1);
    localparam logic [CntW-1:0] Top   = CntW'(TOP_COUNT);
    localparam logic [CntW-1:0] TopM1 = CntW'(TOP_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_RESTORE
    } t_state;

    t_state             r_state;
    logic [CntW-1:0]    r_ra;
    logic [CntW-1:0]    r_rb;
    logic [CntW-1:0]    r_n;
    tnet_pkg::t_rd_kind r_kind;
    logic               r_down_en;

    tnet_pkg::t_cmd     w_cmd;
    logic               w_accept;
    logic               w_reg_hit;
    logic               w_cfg_wr;
    logic               w_sa, w_sb, w_more, w_pick_a;
    logic               w_sa_nx, w_sb_nx;
    logic               w_emit, w_empty, w_last;
    logic               w_rot_a, w_rot_b;
    logic [CntW+RankW-1:0] w_rank_ext;

    assign w_cmd     = tnet_pkg::t_cmd'(i_cmd);
    assign o_tready  = (r_state == ST_IDLE);
    assign w_accept  = i_tvalid && o_tready;
    assign w_reg_hit = (paddr[AddrW-1:2] == tnet_pkg::REG_DOWN_EN);
    assign w_cfg_wr  = psel && penable && pwrite && w_reg_hit;
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? {{(DataW - 1){1'b0}}, r_down_en} : '0;

    assign w_sa     = (r_ra != Top) && i_dp_stat.a_head_vld;
    assign w_sb     = (r_rb != Top) && i_dp_stat.b_head_vld;
    assign w_more   = (r_n != Top) && (w_sa || w_sb);
    assign w_pick_a = w_sa && (!w_sb || i_dp_stat.a_ge_b);
    assign w_sa_nx  = w_pick_a ? ((r_ra + 1'b1 != Top) && i_dp_stat.a_next_vld) : w_sa;
    assign w_sb_nx  = !w_pick_a ? ((r_rb + 1'b1 != Top) && i_dp_stat.b_next_vld) : w_sb;
    assign w_emit   = (r_state == ST_EMIT) && w_more && i_dp_stat.out_free;
    assign w_empty  = (r_state == ST_EMIT) && !w_more && (r_n == '0) && i_dp_stat.out_free;
    assign w_last   = w_empty || (r_n == TopM1) || (!w_sa_nx && !w_sb_nx);
    assign w_rot_a  = (w_emit && w_pick_a) || ((r_state == ST_RESTORE) && (r_ra != Top));
    assign w_rot_b  = (w_emit && !w_pick_a) || ((r_state == ST_RESTORE) && (r_rb != Top));
    assign w_rank_ext = {{RankW{1'b0}}, r_n};

    always_comb begin
        o_dp_cmd.same.clr = w_accept && (w_cmd == tnet_pkg::CMD_CLEAR);
        o_dp_cmd.same.add = w_accept && (w_cmd == tnet_pkg::CMD_ADD_SAME);
        o_dp_cmd.same.rot = w_rot_a;
        o_dp_cmd.down.clr = (w_accept && (w_cmd == tnet_pkg::CMD_CLEAR))
                          || (w_cfg_wr && !pwdata[0]);
        o_dp_cmd.down.add = w_accept && (w_cmd == tnet_pkg::CMD_ADD_DOWN) && r_down_en;
        o_dp_cmd.down.rot = w_rot_b;
        o_dp_cmd.load     = w_emit || w_empty;
        o_dp_cmd.pick_a   = w_emit && w_pick_a;
        o_dp_cmd.pick_b   = w_emit && !w_pick_a;
        o_dp_cmd.last     = w_last;
        o_dp_cmd.rank     = w_rank_ext[RankW-1:0];
        o_dp_cmd.kind     = r_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ra      <= '0;
            r_rb      <= '0;
            r_n       <= '0;
            r_kind    <= tnet_pkg::RD_SAME;
            r_down_en <= 1'b1;
        end else begin
            if (w_cfg_wr) begin
                r_down_en <= pwdata[0];
            end
            if (w_rot_a) begin
                r_ra <= r_ra + 1'b1;
            end
            if (w_rot_b) begin
                r_rb <= r_rb + 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_n <= '0;
                        case (w_cmd)
                            tnet_pkg::CMD_RD_SAME: begin
                                r_kind  <= tnet_pkg::RD_SAME;
                                r_ra    <= '0;
                                r_rb    <= Top;
                                r_state <= ST_EMIT;
                            end
                            tnet_pkg::CMD_RD_DOWN: begin
                                r_kind  <= tnet_pkg::RD_DOWN;
                                r_ra    <= Top;
                                r_rb    <= '0;
                                r_state <= ST_EMIT;
                            end
                            tnet_pkg::CMD_RD_MERGED: begin
                                r_kind  <= tnet_pkg::RD_MERGED;
                                r_ra    <= '0;
                                r_rb    <= '0;
                                r_state <= ST_EMIT;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_n <= r_n + 1'b1;
                        if (w_last) begin
                            r_state <= ST_RESTORE;
                        end
                    end else if (!w_more && (w_empty || (r_n != '0))) begin
                        r_state <= ST_RESTORE;
                    end
                end
                ST_RESTORE: begin
                    if ((r_ra == Top) && (r_rb == Top)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/top_n_error_tracker_unit.sv @@
// Top level of the top-N error tracker: stream ports, APB register port.
// Depends on tnet_pkg, tnet_ctrl and tnet_dp.
//
// An add inserts into a sorted list of TOP_COUNT entries with a single
// parallel compare-and-shift. A read command holds off the input, also
// through any output back-pressure: results are taken from the head of
// each list, which is rotated one entry per cycle while the output
// register is free, and after the last result the lists are rotated on
// until they are back in rank order. Results go out through a one-entry
// output register, so adds may be accepted while the final result of a
// read still waits. Register 0 (byte address 0), bit 0: down class
// enable, reset 1; writing 0 clears the down class.
`default_nettype none

module top_n_error_tracker_unit #(
    parameter int TOP_COUNT  = 10,
    parameter int INDEX_BITS = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [31:0] err_value, [55:32] point_index
    input  wire logic [tnet_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // [2:0] cmd
    input  wire logic [tnet_pkg::CMD_W-1:0]            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [3:0] rank, [35:4] entry_error, [59:36] entry_index,
    // [107:60] error_sum, [139:108] sample_count, [143:140] zero
    output logic [tnet_pkg::M_TDATA_W-1:0]             m_axis_tdata,
    // [0] entry_valid
    output logic                                       m_axis_tuser,
    output logic                                       m_axis_tlast,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tnet_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [tnet_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tnet_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                       pready
);

    localparam int ErrW   = tnet_pkg::ERR_W;
    localparam int KeepW  = (INDEX_BITS < tnet_pkg::IDX_W) ? INDEX_BITS : tnet_pkg::IDX_W;

    tnet_pkg::t_dp_cmd  dp_cmd;
    tnet_pkg::t_dp_stat dp_stat;

    tnet_ctrl #(.TOP_COUNT(TOP_COUNT)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_cmd     (s_axis_tuser),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_dp_cmd  (dp_cmd),
        .i_dp_stat (dp_stat)
    );

    tnet_dp #(.TOP_COUNT(TOP_COUNT), .KEEP_W(KeepW)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .i_err    (s_axis_tdata[ErrW-1:0]),
        .i_idx    (s_axis_tdata[ErrW +: KeepW]),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ design/tnet_checker.sv @@
// Port-level checks for top_n_error_tracker_unit, bound to the top level.
// Depends on tnet_pkg.
`default_nettype none

module tnet_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  s_axis_tvalid,
    input wire logic                                  s_axis_tready,
    input wire logic [tnet_pkg::CMD_W-1:0]            s_axis_tuser,
    input wire logic                                  m_axis_tvalid,
    input wire logic                                  m_axis_tready,
    input wire logic [tnet_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    input wire logic                                  m_axis_tuser,
    input wire logic                                  m_axis_tlast,
    input wire logic                                  pready
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // empty list: a single rank 0 result with zero entry
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[59:0] == '0))
        else $error("malformed empty result");

    // an accepted read deasserts s_axis_tready in the next cycle
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && ((s_axis_tuser == tnet_pkg::CMD_RD_SAME)
        || (s_axis_tuser == tnet_pkg::CMD_RD_DOWN)
        || (s_axis_tuser == tnet_pkg::CMD_RD_MERGED)) |=> !s_axis_tready)
        else $error("input accepted during read");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind top_n_error_tracker_unit tnet_checker u_tnet_checker (.*);

`default_nettype wire
